FILE: design/u16d_pkg.sv
// ---------------------------------------------------------------------------
// u16d_pkg: shared types and constants for the UTF-16 byte stream decoder
// Status codes, byte order mark bytes, surrogate ranges and the result word.
// ---------------------------------------------------------------------------
`default_nettype none

package u16d_pkg;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ODD         = 2'd1,
    ST_LONE_LOW    = 2'd2,
    ST_MISSING_LOW = 2'd3
  } status_t;

  localparam logic [7:0]  BOM_FF    = 8'hFF;
  localparam logic [7:0]  BOM_FE    = 8'hFE;
  localparam logic [15:0] HIGH_MIN  = 16'hD800;
  localparam logic [15:0] HIGH_MAX  = 16'hDBFF;
  localparam logic [15:0] LOW_MIN   = 16'hDC00;
  localparam logic [15:0] LOW_MAX   = 16'hDFFF;

  // One accepted input byte.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        end_of_text;
    status_t     status;
  } result_t;

  function automatic logic is_high_half(input logic [15:0] u);
    return (u >= HIGH_MIN) && (u <= HIGH_MAX);
  endfunction

  function automatic logic is_low_half(input logic [15:0] u);
    return (u >= LOW_MIN) && (u <= LOW_MAX);
  endfunction

endpackage

`default_nettype wire

FILE: design/utf16_byte_stream_decoder.sv
// ---------------------------------------------------------------------------
// utf16_byte_stream_decoder: UTF-16 byte stream decoder with byte order mark
// Pairs bytes into code units, honours a leading mark and checks surrogates.
// ---------------------------------------------------------------------------
//  Channel  | Direction | tdata          | tlast        | tuser
//  s_*      | in        | [7:0] byte_in  | last_byte    | -
//  m_*      | out       | [15:0] code_unit | end_of_text | [0] unit_valid, [2:1] status
//
// Each byte word passes from the input register through the core into the
// result register; a word can be accepted every cycle while m_tready stays high.
// A result word is driven on the master side from the result register.
// A byte that opens a pair, and is not last, gives no result word.
// Reset clears both registers and the decoder state; a stalled master side
// holds its word and, once the input register is full, stalls the slave side.
// ---------------------------------------------------------------------------
`default_nettype none

module utf16_byte_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // [15:0] code_unit
  output logic             m_tlast,
  output logic      [2:0]  m_tuser    // [0] unit_valid, [2:1] status
);

  u16d_pkg::in_word_t s_word;
  u16d_pkg::in_word_t q_word;
  u16d_pkg::result_t  core_res;
  u16d_pkg::result_t  m_res;
  logic               q_valid;
  logic               take;
  logic               out_free;
  logic               core_res_valid;

  assign s_word.byte_in   = s_tdata;
  assign s_word.last_byte = s_tlast;

  // A word is consumed only when the result register can take its result.
  assign take = q_valid && out_free;

  u16d_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_word  (s_word),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_take  (take)
  );

  u16d_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .word      (q_word),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  u16d_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (take && core_res_valid),
    .d_res   (core_res),
    .free    (out_free),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (m_res)
  );

  assign m_tdata = m_res.code_unit;
  assign m_tlast = m_res.end_of_text;
  assign m_tuser = {m_res.status, m_res.unit_valid};

endmodule

`default_nettype wire

FILE: design/u16d_in_stage.sv
// ---------------------------------------------------------------------------
// u16d_in_stage: input register
// Captures one byte word from the slave side and holds it until consumed.
// ---------------------------------------------------------------------------
`default_nettype none

module u16d_in_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_valid,
  output logic                  s_ready,
  input  wire u16d_pkg::in_word_t s_word,
  output logic                  q_valid,
  output u16d_pkg::in_word_t    q_word,
  input  wire logic             q_take
);

  logic               valid;
  u16d_pkg::in_word_t word;

  // A new word may enter when the register is empty or is being emptied.
  assign s_ready = !valid || q_take;
  assign q_valid = valid;
  assign q_word  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      word <= s_word;
    end
  end

endmodule

`default_nettype wire

FILE: design/u16d_core.sv
// ---------------------------------------------------------------------------
// u16d_core: pairing, byte order and surrogate checking
// Holds the decoder state and works out the result of one byte word.
// ---------------------------------------------------------------------------
`default_nettype none

module u16d_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire u16d_pkg::in_word_t word,
  output logic                    res_valid,
  output u16d_pkg::result_t       res
);

  logic              [7:0] held_byte;
  logic                    have_held_byte;
  logic                    at_first_pair;
  logic                    big_endian;
  logic                    expect_low_half;
  u16d_pkg::status_t       error_code;

  logic              [7:0] held_byte_next;
  logic                    have_held_byte_next;
  logic                    at_first_pair_next;
  logic                    big_endian_next;
  logic                    expect_low_half_next;
  u16d_pkg::status_t       error_code_next;

  logic             [15:0] unit;
  logic                    mark;
  logic                    emit_unit;
  u16d_pkg::status_t       end_status;

  always_comb begin
    held_byte_next       = held_byte;
    have_held_byte_next  = have_held_byte;
    at_first_pair_next   = at_first_pair;
    big_endian_next      = big_endian;
    expect_low_half_next = expect_low_half;
    error_code_next      = error_code;
    mark                 = 1'b0;
    emit_unit            = 1'b0;
    end_status           = u16d_pkg::ST_OK;
    unit = big_endian ? {held_byte, word.byte_in} : {word.byte_in, held_byte};

    if (!have_held_byte) begin
      held_byte_next      = word.byte_in;
      have_held_byte_next = 1'b1;
      end_status          = u16d_pkg::ST_ODD;
    end else begin
      have_held_byte_next = 1'b0;
      if (at_first_pair) begin
        at_first_pair_next = 1'b0;
        if (held_byte == u16d_pkg::BOM_FF && word.byte_in == u16d_pkg::BOM_FE) begin
          mark = 1'b1;
        end else if (held_byte == u16d_pkg::BOM_FE && word.byte_in == u16d_pkg::BOM_FF) begin
          mark            = 1'b1;
          big_endian_next = 1'b1;
        end
      end
      if (!mark && error_code == u16d_pkg::ST_OK) begin
        if (expect_low_half) begin
          if (!u16d_pkg::is_low_half(unit)) begin
            error_code_next = u16d_pkg::ST_MISSING_LOW;
          end else begin
            expect_low_half_next = 1'b0;
            emit_unit            = 1'b1;
          end
        end else if (u16d_pkg::is_low_half(unit)) begin
          error_code_next = u16d_pkg::ST_LONE_LOW;
        end else begin
          if (u16d_pkg::is_high_half(unit)) begin
            expect_low_half_next = 1'b1;
          end
          emit_unit = 1'b1;
        end
      end
      // A text that stops after a high surrogate is reported as missing its partner.
      if (error_code_next == u16d_pkg::ST_OK && expect_low_half_next) begin
        end_status = u16d_pkg::ST_MISSING_LOW;
      end else begin
        end_status = error_code_next;
      end
    end

    // The last byte closes the text, and all state starts afresh.
    if (word.last_byte) begin
      have_held_byte_next  = 1'b0;
      at_first_pair_next   = 1'b1;
      big_endian_next      = 1'b0;
      expect_low_half_next = 1'b0;
      error_code_next      = u16d_pkg::ST_OK;
    end
  end

  always_comb begin
    res_valid       = word.last_byte || emit_unit;
    res.code_unit   = emit_unit ? unit : 16'h0000;
    res.unit_valid  = emit_unit;
    res.end_of_text = word.last_byte;
    res.status      = word.last_byte ? end_status : u16d_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_held_byte  <= 1'b0;
      at_first_pair   <= 1'b1;
      big_endian      <= 1'b0;
      expect_low_half <= 1'b0;
      error_code      <= u16d_pkg::ST_OK;
    end else if (take) begin
      have_held_byte  <= have_held_byte_next;
      at_first_pair   <= at_first_pair_next;
      big_endian      <= big_endian_next;
      expect_low_half <= expect_low_half_next;
      error_code      <= error_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_byte <= held_byte_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/u16d_out_stage.sv
// ---------------------------------------------------------------------------
// u16d_out_stage: result register
// Holds one result word for the master side until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module u16d_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire u16d_pkg::result_t d_res,
  output logic                   free,
  output logic                   m_valid,
  input  wire logic              m_ready,
  output u16d_pkg::result_t      m_res
);

  logic              valid;
  u16d_pkg::result_t res;

  assign free    = !valid || m_ready;
  assign m_valid = valid;
  assign m_res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res <= d_res;
    end
  end

endmodule

`default_nettype wire

FILE: design/u16d_checker.sv
// ---------------------------------------------------------------------------
// u16d_checker: port checks for the UTF-16 byte stream decoder
// Watches the master side for result word rules and reset behaviour.
// ---------------------------------------------------------------------------
`default_nettype none

module u16d_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic [2:0]  m_tuser
);

  // A stalled result word must not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result word changed while stalled");

  // Without a decoded unit the code unit field reads zero.
  a_zero_unit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 16'h0000)
    else $error("code unit not zero on a word without a unit");

  // Words inside a text always carry a unit and a clean status.
  a_mid_text: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser[0] && m_tuser[2:1] == 2'b00)
    else $error("word inside a text without a unit or with a status");

  // Reset leaves the master side empty.
  a_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("result word present straight after reset");

endmodule

bind utf16_byte_stream_decoder u16d_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire
